### hw/rtl/indexed_max_priority_queue_unit_macros.svh
// Assertion macros for the indexed max priority queue unit
`ifndef INDEXED_MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define INDEXED_MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH
// implication check under reset
`define IMPQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check under reset
`define IMPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hw/rtl/impq_pkg.sv
// Types and constants for the indexed max priority queue unit
package impq_pkg;
  localparam int unsigned Capacity    = 256;
  localparam int unsigned VertexCount = 256;
  localparam int unsigned SlotW       = $clog2(Capacity);
  localparam int unsigned CountW      = SlotW + 1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_RAISE  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NEGKEY  = 3'd2,
    ST_SMALLER = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_ABSENT  = 3'd5,
    ST_PRESENT = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  vertex;
    logic [31:0] key;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  top_vertex;
    logic [8:0]  entry_count;
  } out_item_t;

  // one-hot sequencer states
  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_LOOKUP  = 20'h00002,
    S_CHECK   = 20'h00004,
    S_DECIDE  = 20'h00008,
    S_UP_RD   = 20'h00010,
    S_UP_RDK  = 20'h00020,
    S_UP_CMP  = 20'h00040,
    S_UP_DEC  = 20'h00080,
    S_UP_SWP  = 20'h00100,
    S_POP_RD  = 20'h00200,
    S_POP_RDK = 20'h00400,
    S_POP_MV  = 20'h00800,
    S_DN_RDL  = 20'h01000,
    S_DN_RDLK = 20'h02000,
    S_DN_RDR  = 20'h04000,
    S_DN_CMPL = 20'h08000,
    S_DN_CMPR = 20'h10000,
    S_DN_SWA  = 20'h20000,
    S_DN_SWB  = 20'h40000,
    S_DONE    = 20'h80000
  } state_e;

  // compare request to the shared key comparator
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;
endpackage

### hw/rtl/indexed_max_priority_queue_unit.sv
// Indexed binary max heap: top level with sequencer, stores and shared comparator
// Insert/raise writes the key and climbs; pop moves the last entry to the root and sinks it; a
// rejected command, a no-op or a pop that empties the heap goes straight to the result.
// Throughput: one item at a time, the next transfer taken in the cycle after the result loads;
// set by the stores, each with one write and one read port, and the one comparator.
// Reset: count, state, valid bits clear at once.
`include "indexed_max_priority_queue_unit_macros.svh"
module indexed_max_priority_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  impq_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output impq_pkg::out_item_t out_data_o
);
  import impq_pkg::*;

  // stores: heap slot -> vertex, vertex -> biased key, vertex -> slot
  logic [7:0]             heap_mem [Capacity];
  logic [31:0]            key_mem  [VertexCount];
  logic [SlotW-1:0]       pos_mem  [VertexCount];
  logic [VertexCount-1:0] pos_vld_q;

  state_e state_q, state_d;
  in_item_t item_q;
  logic [CountW-1:0] total_q, total_d;
  logic [SlotW-1:0] slot_q, up_q, best_q;
  logic [7:0]  va_q, vb_q, vc_q, vbest_q;  // moving vertex, parent/left, right, chosen child
  logic [31:0] ka_q, kb_q;                 // key of moving vertex, key of left child
  logic        has_r_q, gt_l_q;
  out_item_t   rslt_q, res_q;
  logic        out_valid_q;

  // keys kept with the sign bit flipped so an unsigned compare orders them
  logic [31:0] biased;
  assign biased = item_q.key ^ 32'h8000_0000;

  logic present;
  assign present = pos_vld_q[item_q.vertex];

  cmp_req_t creq;
  logic     gt;
  impq_cmp u_cmp (.clk_i(clk_i), .req_i(creq), .gt_o(gt));

  // one write and one registered read per store and cycle
  logic             hw_en;
  logic [SlotW-1:0] hw_addr;
  logic [7:0]       hw_data;
  logic [SlotW-1:0] hr_addr;
  logic [7:0]       heap_rd_q;
  logic             kw_en;
  logic [7:0]       kr_addr;
  logic [31:0]      key_rd_q;
  logic             pw_en;
  logic [7:0]       pw_addr;
  logic [SlotW-1:0] pw_data;
  logic [SlotW-1:0] pos_rd_q;

  always_ff @(posedge clk_i) begin
    if (hw_en) heap_mem[hw_addr] <= hw_data;
    heap_rd_q <= heap_mem[hr_addr];
  end
  always_ff @(posedge clk_i) begin
    if (kw_en) key_mem[item_q.vertex] <= biased;
    key_rd_q <= key_mem[kr_addr];
  end
  always_ff @(posedge clk_i) begin
    if (pw_en) pos_mem[pw_addr] <= pw_data;
    pos_rd_q <= pos_mem[item_q.vertex];
  end

  // heap index arithmetic
  logic [SlotW-1:0] parent;
  assign parent = (slot_q - SlotW'(1)) >> 1;
  logic [CountW:0] left_w, right_w, total_x;
  assign left_w  = {1'b0, slot_q, 1'b1};
  assign right_w = left_w + (CountW+1)'(1);
  assign total_x = {1'b0, total_q};

  // outcome of the checks, valid in DECIDE; gt there is "stored key above new key"
  status_e status_d;
  logic    cmd_ok;
  always_comb begin
    status_d = ST_OK;
    unique case (kind_e'(item_q.kind))
      KIND_INSERT: begin
        // a full heap wins over every other rejection
        priority if (total_q == CountW'(Capacity)) status_d = ST_FULL;
        else if (item_q.key[31]) status_d = ST_NEGKEY;
        else if (present) status_d = ST_PRESENT;
        else status_d = ST_OK;
      end
      KIND_POP: begin
        if (total_q == '0) status_d = ST_EMPTY;
        else status_d = ST_OK;
      end
      KIND_RAISE: begin
        // an equal key is accepted and moves nothing
        priority if (!present) status_d = ST_ABSENT;
        else if (gt) status_d = ST_SMALLER;
        else status_d = ST_OK;
      end
      KIND_NONE: status_d = ST_OK;
    endcase
  end
  assign cmd_ok = (status_d == ST_OK);

  always_comb begin
    total_d = total_q;
    if (state_q == S_DECIDE && cmd_ok) begin
      if (item_q.kind == KIND_INSERT) total_d = total_q + CountW'(1);
      else if (item_q.kind == KIND_POP) total_d = total_q - CountW'(1);
    end
  end

  // sequencer: next state, store ports and comparator operands
  always_comb begin
    state_d = state_q;
    hr_addr = slot_q;
    kr_addr = va_q;
    hw_en = 1'b0; hw_addr = slot_q; hw_data = va_q;
    pw_en = 1'b0; pw_addr = va_q; pw_data = slot_q;
    kw_en = 1'b0;
    creq.a = ka_q; creq.b = kb_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOKUP;
      S_LOOKUP: begin
        // root vertex and the stored key of the addressed vertex
        hr_addr = '0; kr_addr = item_q.vertex;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        hr_addr = '0;
        creq.a = key_rd_q; creq.b = biased;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_DONE;
        if (cmd_ok) begin
          unique case (kind_e'(item_q.kind))
            KIND_INSERT: begin
              // new vertex goes to the first free slot, then climbs
              kw_en = 1'b1;
              hw_en = 1'b1; hw_addr = SlotW'(total_q); hw_data = item_q.vertex;
              pw_en = 1'b1; pw_addr = item_q.vertex; pw_data = SlotW'(total_q);
              state_d = S_UP_RD;
            end
            KIND_POP: if (total_q != CountW'(1)) state_d = S_POP_RD;
            KIND_RAISE: begin
              kw_en = 1'b1;
              state_d = S_UP_RD;
            end
            KIND_NONE: ;
          endcase
        end
      end
      // climb: read parent vertex, its key, compare, swap on strictly greater
      S_UP_RD: begin
        hr_addr = parent;
        state_d = (slot_q == '0) ? S_DONE : S_UP_RDK;
      end
      S_UP_RDK: begin
        kr_addr = heap_rd_q;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        creq.a = ka_q; creq.b = key_rd_q;
        state_d = S_UP_DEC;
      end
      S_UP_DEC: begin
        if (gt) begin
          hw_en = 1'b1; hw_addr = up_q; hw_data = va_q;
          pw_en = 1'b1; pw_addr = va_q; pw_data = up_q;
          state_d = S_UP_SWP;
        end else state_d = S_DONE;
      end
      S_UP_SWP: begin
        hw_en = 1'b1; hw_addr = slot_q; hw_data = vb_q;
        pw_en = 1'b1; pw_addr = vb_q; pw_data = slot_q;
        state_d = S_UP_RD;
      end
      // pop: last entry moves to the root, then sinks
      S_POP_RD: begin
        hr_addr = SlotW'(total_q);
        state_d = S_POP_RDK;
      end
      S_POP_RDK: begin
        kr_addr = heap_rd_q;
        state_d = S_POP_MV;
      end
      S_POP_MV: begin
        hw_en = 1'b1; hw_addr = '0; hw_data = va_q;
        pw_en = 1'b1; pw_addr = va_q; pw_data = '0;
        state_d = S_DN_RDL;
      end
      // sink: read both children and their keys, pick the strictly larger one
      S_DN_RDL: begin
        hr_addr = SlotW'(left_w);
        state_d = (left_w >= total_x) ? S_DONE : S_DN_RDLK;
      end
      S_DN_RDLK: begin
        kr_addr = heap_rd_q;
        hr_addr = SlotW'(right_w);
        state_d = S_DN_RDR;
      end
      S_DN_RDR: begin
        kr_addr = heap_rd_q;
        creq.a = key_rd_q; creq.b = ka_q;
        state_d = S_DN_CMPL;
      end
      S_DN_CMPL: begin
        // right child against the better of parent and left; ties keep the left
        creq.a = key_rd_q; creq.b = gt ? kb_q : ka_q;
        state_d = S_DN_CMPR;
      end
      S_DN_CMPR: begin
        if ((has_r_q && gt) || gt_l_q) state_d = S_DN_SWA;
        else state_d = S_DONE;
      end
      S_DN_SWA: begin
        hw_en = 1'b1; hw_addr = best_q; hw_data = va_q;
        pw_en = 1'b1; pw_addr = va_q; pw_data = best_q;
        state_d = S_DN_SWB;
      end
      S_DN_SWB: begin
        hw_en = 1'b1; hw_addr = slot_q; hw_data = vbest_q;
        pw_en = 1'b1; pw_addr = vbest_q; pw_data = slot_q;
        state_d = S_DN_RDL;
      end
      // a waiting result holds only this step
      S_DONE: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; total_q <= '0; pos_vld_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == S_DECIDE && cmd_ok) begin
        if (item_q.kind == KIND_INSERT) pos_vld_q[item_q.vertex] <= 1'b1;
        else if (item_q.kind == KIND_POP) pos_vld_q[heap_rd_q] <= 1'b0;
      end
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_valid_i) item_q <= in_data_i;
      S_DECIDE: begin
        rslt_q.status      <= status_d;
        rslt_q.top_vertex  <= (cmd_ok && item_q.kind == KIND_POP) ? heap_rd_q : 8'd0;
        rslt_q.entry_count <= total_d;
        va_q   <= item_q.vertex;
        ka_q   <= biased;
        slot_q <= (item_q.kind == KIND_RAISE) ? pos_rd_q : SlotW'(total_q);
      end
      S_UP_RD: up_q <= parent;
      S_UP_RDK: vb_q <= heap_rd_q;
      S_UP_SWP: slot_q <= up_q;
      S_POP_RDK: va_q <= heap_rd_q;
      S_POP_MV: begin
        ka_q   <= key_rd_q;
        slot_q <= '0;
      end
      S_DN_RDLK: begin
        vb_q    <= heap_rd_q;
        has_r_q <= right_w < total_x;
      end
      S_DN_RDR: begin
        kb_q <= key_rd_q;
        vc_q <= heap_rd_q;
      end
      S_DN_CMPL: gt_l_q <= gt;
      S_DN_CMPR: begin
        if (has_r_q && gt) begin
          best_q <= SlotW'(right_w); vbest_q <= vc_q;
        end else begin
          best_q <= SlotW'(left_w); vbest_q <= vb_q;
        end
      end
      S_DN_SWB: slot_q <= best_q;
      S_DONE: if (!out_valid_q || out_ready_i) res_q <= rslt_q;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  `IMPQ_ASSERT_IMP(a_busy_not_ready, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `IMPQ_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, total_q <= CountW'(Capacity))
  `IMPQ_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, state_q != S_IDLE)
  `IMPQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
endmodule

### hw/rtl/impq_cmp.sv
// Shared unsigned key comparator with registered result
module impq_cmp (
  input  logic               clk_i,
  input  impq_pkg::cmp_req_t req_i,
  output logic               gt_o
);
  import impq_pkg::*;
  logic gt_q;
  always_ff @(posedge clk_i) begin
    gt_q <= req_i.a > req_i.b;
  end
  assign gt_o = gt_q;
endmodule

### tb/sv/indexed_max_priority_queue_unit_tb.sv
// Testbench for the indexed max priority queue unit: directed and random commands vs a local heap
module indexed_max_priority_queue_unit_tb;
  import impq_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  always #1 clk_i = ~clk_i;

  indexed_max_priority_queue_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // shadow heap; keys held with the sign bit flipped so unsigned compare orders them
  logic [7:0]  shadow_order [256];
  logic [31:0] shadow_key   [256];
  int unsigned shadow_pos   [256];
  int unsigned shadow_total;

  out_item_t   pending_results [$];
  int          error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  function automatic void put_vertex(int unsigned slot, logic [7:0] v);
    shadow_order[slot] = v;
    shadow_pos[v]      = slot + 1;
  endfunction

  function automatic void swap_slots(int unsigned x, int unsigned y);
    logic [7:0] a;
    logic [7:0] b;
    a = shadow_order[x];
    b = shadow_order[y];
    put_vertex(x, b);
    put_vertex(y, a);
  endfunction

  // climb while strictly greater than the parent
  function automatic void climb(int unsigned slot);
    int unsigned up;
    while (slot > 0) begin
      up = (slot - 1) / 2;
      if (!(shadow_key[shadow_order[up]] < shadow_key[shadow_order[slot]])) break;
      swap_slots(up, slot);
      slot = up;
    end
  endfunction

  // sink towards the larger child; ties leave the parent in place
  function automatic void sink(int unsigned slot);
    int unsigned l;
    int unsigned best;
    forever begin
      l    = 2 * slot + 1;
      best = slot;
      if (l < shadow_total &&
          shadow_key[shadow_order[l]] > shadow_key[shadow_order[best]]) best = l;
      if (l + 1 < shadow_total &&
          shadow_key[shadow_order[l+1]] > shadow_key[shadow_order[best]]) best = l + 1;
      if (best == slot) break;
      swap_slots(slot, best);
      slot = best;
    end
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t   res;
    logic [31:0] biased;
    logic [7:0]  t;
    int unsigned p;
    res    = '0;
    biased = it.key ^ 32'h8000_0000;
    res.status = ST_OK;
    case (kind_e'(it.kind))
      KIND_INSERT: begin
        if (shadow_total >= Capacity) res.status = ST_FULL;
        else if (it.key[31]) res.status = ST_NEGKEY;
        else if (shadow_pos[it.vertex] != 0) res.status = ST_PRESENT;
        else begin
          shadow_key[it.vertex] = biased;
          put_vertex(shadow_total, it.vertex);
          shadow_total++;
          climb(shadow_total - 1);
        end
      end
      KIND_POP: begin
        if (shadow_total == 0) res.status = ST_EMPTY;
        else begin
          t = shadow_order[0];
          res.top_vertex = t;
          shadow_pos[t] = 0;
          shadow_total--;
          if (shadow_total > 0) begin
            put_vertex(0, shadow_order[shadow_total]);
            sink(0);
          end
        end
      end
      KIND_RAISE: begin
        p = shadow_pos[it.vertex];
        if (p == 0 || p > shadow_total) res.status = ST_ABSENT;
        else if (biased < shadow_key[it.vertex]) res.status = ST_SMALLER;
        else begin
          shadow_key[it.vertex] = biased;
          climb(p - 1);
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_total[8:0];
    return res;
  endfunction

  // both sides sampled mid-cycle, when everything driven at the edge has settled
  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && in_valid && in_ready)
      pending_results.push_back(apply_command(in_data));
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.top_vertex !== want.top_vertex) begin
          $error("top_vertex: expected %0d, got %0d", want.top_vertex, out_data.top_vertex);
          error_count++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 out_data.entry_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i)
    out_ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);

  // one transfer; returns at the edge where it was taken
  task automatic send_cmd(kind_e k, logic [7:0] v, logic [31:0] key);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data.kind   <= k;
    in_data.vertex <= v;
    in_data.key    <= key;
    do begin
      @(negedge clk_i);
      rdy = in_ready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic test_corner_cases();
    send_cmd(KIND_POP, 8'd0, 32'd0);              // pop on empty
    send_cmd(KIND_RAISE, 8'd9, 32'd5);            // raise absent
    send_cmd(KIND_INSERT, 8'd1, 32'hFFFF_FFFF);   // -1 rejected
    send_cmd(KIND_INSERT, 8'd1, 32'h8000_0000);   // most negative rejected
    send_cmd(KIND_INSERT, 8'd0, 32'd0);
    send_cmd(KIND_INSERT, 8'd255, 32'h7FFF_FFFF);
    send_cmd(KIND_INSERT, 8'd0, 32'd3);           // already present
    send_cmd(KIND_INSERT, 8'd7, 32'd100);
    send_cmd(KIND_INSERT, 8'd8, 32'd100);         // tie with sibling
    send_cmd(KIND_RAISE, 8'd7, 32'd50);           // smaller
    send_cmd(KIND_RAISE, 8'd7, 32'd100);          // equal: accepted, no move
    send_cmd(KIND_RAISE, 8'd0, 32'h7FFF_FFFF);    // ties the top, stays below
    send_cmd(KIND_RAISE, 8'd8, 32'hFFFF_FFF6);    // -10, smaller
    send_cmd(KIND_NONE, 8'hAA, 32'h5555_5555);
    send_cmd(KIND_POP, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(KIND_RAISE, 8'd255, 32'h7FFF_FFFF);  // popped vertex is absent
    repeat (5) send_cmd(KIND_POP, 8'd0, 32'd0);
    drain_results();
  endtask

  task automatic test_full_heap();
    for (int i = 0; i < 256; i++) send_cmd(KIND_INSERT, i[7:0], $urandom() >> 1);
    send_cmd(KIND_INSERT, 8'd3, 32'd1);           // full
    send_cmd(KIND_INSERT, 8'd3, 32'hFFFF_FFFF);   // full wins over negative
    send_cmd(KIND_RAISE, 8'd200, 32'h7FFF_FFFF);
    for (int i = 0; i < 100; i++) send_cmd(KIND_POP, 8'd0, 32'd0);
    drain_results();
  endtask

  task automatic send_random_cmd();
    int unsigned roll;
    logic [7:0]  v;
    logic [31:0] raw;
    roll = $urandom_range(99);
    if (roll < 40) begin
      raw = (roll < 4) ? ($urandom() | 32'h8000_0000) : ($urandom() >> ($urandom_range(1, 31)));
      send_cmd(KIND_INSERT, 8'($urandom_range(255)), raw);
    end else if (roll < 68) begin
      send_cmd(KIND_POP, 8'($urandom_range(255)), $urandom());
    end else if (roll < 95 && shadow_total > 0) begin
      v   = shadow_order[$urandom_range(shadow_total - 1)];
      raw = shadow_key[v] ^ 32'h8000_0000;
      if (roll < 72) raw = raw - $urandom_range(1, 100);
      else if (raw < 32'h7FFF_0000) raw = raw + $urandom_range(0, 65535);
      send_cmd(KIND_RAISE, v, raw);
    end else if (roll < 97) begin
      send_cmd(KIND_RAISE, 8'($urandom_range(255)), $urandom());
    end else begin
      send_cmd(KIND_NONE, 8'($urandom_range(255)), $urandom());
    end
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_random_cmd();
    drain_results();
  endtask

  initial begin
    error_count   = 0;
    shadow_total  = 0;
    send_idle_pct = 15;
    recv_idle_pct = 75;
    foreach (shadow_pos[i]) shadow_pos[i] = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_cases();
    test_random_traffic(90);
    send_idle_pct = 75;
    recv_idle_pct = 15;
    test_full_heap();
    test_random_traffic(90);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(90);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end
endmodule
